### sv/ppim_pkg.sv
package ppim_pkg;

  // Field and datapath widths
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int H_W    = 31;
  localparam int PROD_W = 2 * DATA_W;
  localparam int WIDE_W = DATA_W + FRAC_W;

  // Divider: numerator magnitude and denominator widths
  localparam int NUM_W   = PROD_W;
  localparam int DEN_W   = DATA_W + 1;
  localparam int DIV_LAT = NUM_W + 1;

  // Square root of the Q32.32 sum of squares
  localparam int SQ_W     = PROD_W;
  localparam int RHO_W    = SQ_W / 2;
  localparam int SQRT_LAT = RHO_W;

  localparam logic [H_W-1:0] H_RESET = H_W'(1) << FRAC_W;

  typedef logic signed [DATA_W-1:0] q_t;

endpackage

### sv/ppim_div.sv
module ppim_div (
  input  logic                        clk_i,
  input  logic                        neg_i,
  input  logic [ppim_pkg::NUM_W-1:0]  num_i,
  input  logic [ppim_pkg::DEN_W-1:0]  den_i,
  input  logic                        den_ok_i,
  output ppim_pkg::q_t                quo_o
);
  import ppim_pkg::*;

  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'((65'd1 << (DATA_W - 1)) - 65'd1);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(65'd1 << (DATA_W - 1));

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic             neg_q [NUM_W];
  logic             ok_q  [NUM_W];
  q_t               quo_q;

  // Saturate a signed quotient given as sign and magnitude
  function automatic q_t sat_mag(input logic neg, input logic [NUM_W-1:0] mag);
    q_t r;
    if (!neg) begin
      r = (mag > POS_LIM) ? q_t'(POS_LIM) : q_t'(mag);
    end else begin
      r = (mag > NEG_LIM) ? q_t'(NEG_LIM) : -q_t'(mag);
    end
    return r;
  endfunction

  // One restoring step per stage, most significant quotient bit first
  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic             ok_in;
    logic [DEN_W:0]   sh;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign ok_in  = den_ok_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign nq_in  = nq_q[g-1];
      assign den_in = den_q[g-1];
      assign neg_in = neg_q[g-1];
      assign ok_in  = ok_q[g-1];
    end

    assign sh = {rem_in, nq_in[NUM_W-1]};
    assign ge = (sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];
      nq_q[g]  <= {nq_in[NUM_W-2:0], ge};
      den_q[g] <= den_in;
      neg_q[g] <= neg_in;
      ok_q[g]  <= ok_in;
    end
  end

  // Saturate, or drop to zero for a denominator that is not positive
  always_ff @(posedge clk_i) begin
    quo_q <= ok_q[NUM_W-1] ? sat_mag(neg_q[NUM_W-1], nq_q[NUM_W-1]) : '0;
  end

  assign quo_o = quo_q;

endmodule

### sv/ppim_sqrt.sv
module ppim_sqrt (
  input  logic                        clk_i,
  input  logic [ppim_pkg::SQ_W-1:0]   sum_i,
  output logic [ppim_pkg::RHO_W-1:0]  rho_o
);
  import ppim_pkg::*;

  logic [SQ_W-1:0] n_q [SQRT_LAT];
  logic [SQ_W-1:0] r_q [SQRT_LAT];

  // One result bit per stage, trial bit walking down two places each step
  for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT_C = SQ_W'(1) << (SQ_W - 2 - 2 * g);
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] t;
    logic            ge;

    if (g == 0) begin : g_first
      assign n_in = sum_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[g-1];
      assign r_in = r_q[g-1];
    end

    assign t  = r_in + BIT_C;
    assign ge = (n_in >= t);

    always_ff @(posedge clk_i) begin
      n_q[g] <= ge ? n_in - t : n_in;
      r_q[g] <= ge ? (r_in >> 1) + BIT_C : r_in >> 1;
    end
  end

  assign rho_o = r_q[SQRT_LAT-1][RHO_W-1:0];

endmodule

### sv/paraboloid_point_interaction_matrix_top.sv
// Paraboloid-mirror point interaction matrix, one point per transaction.
// Input channel: pulse start with img_x/img_y (normalized image point) and
// cam_px/cam_py/cam_pz (camera-frame point), all signed Q16.16. A
// transaction is taken at a rising edge where start is high and busy is low.
// busy stays low: the datapath is fully pipelined and takes one point every
// cycle, so throughput is one point per clock.
// Result channel: out_strobe_o is high for exactly one cycle with the eleven
// matrix entries and the degenerate flag, taken at the edge that ends that
// cycle; the receiver cannot stall, so results are never held. The pipeline
// depth is set by the chain square root (32 stages), division for z
// (65 stages), divisions for w and the sums of squares over h (65 stages)
// and the divisions by rho (65 stages); the square root yields one result
// bit per stage, each divider a quotient bit per stage but its last.
// Configuration: cfg_valid_i/cfg_ready_o write the mirror parameter h
// (unsigned Q15.16, 0 is used as the smallest nonzero value). Write it
// only while no point is in flight. Reset sets h to 1.0 and clears all
// valid bits; results in flight are dropped.
module paraboloid_point_interaction_matrix_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ppim_pkg::q_t               img_x_i,
  input  ppim_pkg::q_t               img_y_i,
  input  ppim_pkg::q_t               cam_px_i,
  input  ppim_pkg::q_t               cam_py_i,
  input  ppim_pkg::q_t               cam_pz_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ppim_pkg::H_W-1:0]   cfg_data_i,
  output logic                       out_strobe_o,
  output ppim_pkg::q_t               u_vx_o,
  output ppim_pkg::q_t               cross_vel_o,
  output ppim_pkg::q_t               u_vz_o,
  output ppim_pkg::q_t               u_wx_o,
  output ppim_pkg::q_t               u_wy_o,
  output ppim_pkg::q_t               u_wz_o,
  output ppim_pkg::q_t               v_vy_o,
  output ppim_pkg::q_t               v_vz_o,
  output ppim_pkg::q_t               v_wx_o,
  output ppim_pkg::q_t               v_wy_o,
  output ppim_pkg::q_t               v_wz_o,
  output logic                       degenerate_o
);
  import ppim_pkg::*;

  // Pipeline timing, in register stages after the accepting edge
  localparam int T_IN  = 0;
  localparam int T_SQ  = 1;
  localparam int T_PRE = 2;
  localparam int T_RHO = T_PRE + SQRT_LAT;
  localparam int T_S   = T_RHO + 1;
  localparam int T_XYH = T_PRE + DIV_LAT;
  localparam int T_Z   = T_S + DIV_LAT;
  localparam int T_ZSQ = T_Z + 1;
  localparam int T_NUM = T_Z + 2;
  localparam int T_W   = T_NUM + DIV_LAT;
  localparam int T_RN  = T_W + 1;
  localparam int T_RW  = T_RN + 1;
  localparam int T_Q   = T_RN + DIV_LAT;
  localparam int T_OUT = T_Q + 1;

  localparam int S_W = RHO_W + 2;

  // Divisions by rho
  localparam int R_TY  = 0;
  localparam int R_TX  = 1;
  localparam int R_XYH = 2;
  localparam int R_X   = 3;
  localparam int R_Y   = 4;
  localparam int R_NUM = 5;

  localparam logic signed [WIDE_W-1:0] W_HI = WIDE_W'((65'd1 << (DATA_W - 1)) - 65'd1);
  localparam logic signed [WIDE_W-1:0] W_LO = -W_HI - WIDE_W'(1);

  function automatic q_t sat_w(input logic signed [WIDE_W-1:0] v);
    q_t r;
    if (v > W_HI) begin
      r = q_t'(W_HI);
    end else if (v < W_LO) begin
      r = q_t'(W_LO);
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] mag_of(input logic signed [PROD_W-1:0] v);
    return v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
  endfunction

  function automatic logic signed [WIDE_W-1:0] wide(input q_t v);
    return WIDE_W'(v);
  endfunction

  logic             accept;
  logic [H_W-1:0]   h_q;
  logic [DEN_W-1:0] h_den;

  logic vld_q [T_IN:T_OUT];

  q_t x_q  [T_IN:T_Q];
  q_t y_q  [T_IN:T_Q];
  q_t cz_q [T_IN:T_RHO];
  q_t cx_q;
  q_t cy_q;

  logic [PROD_W-1:0]        xx_q [T_SQ:T_ZSQ];
  logic [PROD_W-1:0]        yy_q [T_SQ:T_ZSQ];
  logic [PROD_W-1:0]        cxx_q, cyy_q, czz_q;
  logic signed [PROD_W-1:0] xy_p_q, hz_p_q;

  logic [SQ_W-1:0]   sum3_q;
  logic              xy_neg_q;
  logic [NUM_W-1:0]  xy_mag_q;
  logic              hz_neg_q [T_PRE:T_S];
  logic [NUM_W-1:0]  hz_mag_q [T_PRE:T_S];

  logic [RHO_W-1:0]        rho_w;
  logic [RHO_W-1:0]        rho_q [T_RHO+1:T_W];
  logic signed [S_W-1:0]   s_d;
  logic signed [S_W-1:0]   s_q   [T_S:T_NUM];
  logic                    deg_q [T_S:T_Q];

  q_t xyh_w;
  q_t xyh_q [T_XYH+1:T_Q];
  q_t z_w;

  logic [PROD_W-1:0] zz_q;
  logic              wn_neg_q [T_ZSQ:T_NUM];
  logic [NUM_W-1:0]  wn_mag_q [T_ZSQ:T_NUM];
  logic [NUM_W-1:0]  numy_q, numx_q;

  q_t w_w, ty_w, tx_w;
  q_t w_q  [T_RN:T_Q];
  q_t ty_q [T_RN:T_Q];
  q_t tx_q [T_RN:T_Q];

  logic signed [PROD_W-1:0] rw_p_q;
  q_t                       rw_q [T_RW:T_Q];

  logic             rn_neg_q [R_NUM];
  logic [NUM_W-1:0] rn_mag_q [R_NUM];
  logic [DEN_W-1:0] rden_q;
  logic             rok_q;
  q_t               rq_w [R_NUM];

  q_t   u_vx_q, cross_vel_q, u_vz_q, u_wx_q, u_wy_q, u_wz_q;
  q_t   v_vy_q, v_vz_q, v_wx_q, v_wy_q, v_wz_q;
  logic degenerate_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign h_den       = (h_q == '0) ? DEN_W'(1) : DEN_W'(h_q);

  // Hold the mirror parameter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      h_q <= cfg_data_i;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = T_IN; i <= T_OUT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[T_IN] <= accept;
      for (int i = T_IN + 1; i <= T_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Capture the transaction and carry the image point along
  always_ff @(posedge clk_i) begin
    x_q[T_IN]  <= img_x_i;
    y_q[T_IN]  <= img_y_i;
    cx_q       <= cam_px_i;
    cy_q       <= cam_py_i;
    cz_q[T_IN] <= cam_pz_i;
    for (int i = T_IN + 1; i <= T_Q; i++) begin
      x_q[i] <= x_q[i-1];
      y_q[i] <= y_q[i-1];
    end
    for (int i = T_IN + 1; i <= T_RHO; i++) cz_q[i] <= cz_q[i-1];
  end

  // Form squares and products
  always_ff @(posedge clk_i) begin
    xx_q[T_SQ] <= PROD_W'(PROD_W'(x_q[T_IN]) * PROD_W'(x_q[T_IN]));
    yy_q[T_SQ] <= PROD_W'(PROD_W'(y_q[T_IN]) * PROD_W'(y_q[T_IN]));
    for (int i = T_SQ + 1; i <= T_ZSQ; i++) begin
      xx_q[i] <= xx_q[i-1];
      yy_q[i] <= yy_q[i-1];
    end
    cxx_q  <= PROD_W'(PROD_W'(cx_q) * PROD_W'(cx_q));
    cyy_q  <= PROD_W'(PROD_W'(cy_q) * PROD_W'(cy_q));
    czz_q  <= PROD_W'(PROD_W'(cz_q[T_IN]) * PROD_W'(cz_q[T_IN]));
    xy_p_q <= PROD_W'(x_q[T_IN]) * PROD_W'(y_q[T_IN]);
    hz_p_q <= PROD_W'($signed(h_den)) * PROD_W'(cz_q[T_IN]);
  end

  // Sum the squares, split the products into sign and magnitude
  always_ff @(posedge clk_i) begin
    sum3_q          <= cxx_q + cyy_q + czz_q;
    xy_neg_q        <= xy_p_q[PROD_W-1];
    xy_mag_q        <= mag_of(xy_p_q);
    hz_neg_q[T_PRE] <= hz_p_q[PROD_W-1];
    hz_mag_q[T_PRE] <= mag_of(hz_p_q);
    for (int i = T_PRE + 1; i <= T_S; i++) begin
      hz_neg_q[i] <= hz_neg_q[i-1];
      hz_mag_q[i] <= hz_mag_q[i-1];
    end
  end

  ppim_sqrt u_sqrt (
    .clk_i (clk_i),
    .sum_i (sum3_q),
    .rho_o (rho_w)
  );

  ppim_div u_div_xyh (
    .clk_i    (clk_i),
    .neg_i    (xy_neg_q),
    .num_i    (xy_mag_q),
    .den_i    (h_den),
    .den_ok_i (1'b1),
    .quo_o    (xyh_w)
  );

  assign s_d = S_W'($signed({1'b0, rho_w})) + S_W'(cz_q[T_RHO]);

  // Form rho + Z and the degenerate flag
  always_ff @(posedge clk_i) begin
    rho_q[T_RHO+1] <= rho_w;
    for (int i = T_RHO + 2; i <= T_W; i++) rho_q[i] <= rho_q[i-1];
    s_q[T_S]   <= s_d;
    deg_q[T_S] <= (rho_w == '0) || (s_d == '0);
    for (int i = T_S + 1; i <= T_NUM; i++) s_q[i] <= s_q[i-1];
    for (int i = T_S + 1; i <= T_Q; i++) deg_q[i] <= deg_q[i-1];
    xyh_q[T_XYH+1] <= xyh_w;
    for (int i = T_XYH + 2; i <= T_Q; i++) xyh_q[i] <= xyh_q[i-1];
  end

  ppim_div u_div_z (
    .clk_i    (clk_i),
    .neg_i    (hz_neg_q[T_S]),
    .num_i    (hz_mag_q[T_S]),
    .den_i    (s_q[T_S][DEN_W-1:0]),
    .den_ok_i (s_q[T_S] > 0),
    .quo_o    (z_w)
  );

  // Square z and scale it for the division giving w
  always_ff @(posedge clk_i) begin
    zz_q            <= PROD_W'(PROD_W'(z_w) * PROD_W'(z_w));
    wn_neg_q[T_ZSQ] <= z_w[DATA_W-1];
    wn_mag_q[T_ZSQ] <= mag_of(PROD_W'(z_w)) << FRAC_W;
    wn_neg_q[T_NUM] <= wn_neg_q[T_ZSQ];
    wn_mag_q[T_NUM] <= wn_mag_q[T_ZSQ];
    numy_q          <= yy_q[T_ZSQ] + zz_q;
    numx_q          <= xx_q[T_ZSQ] + zz_q;
  end

  ppim_div u_div_w (
    .clk_i    (clk_i),
    .neg_i    (wn_neg_q[T_NUM]),
    .num_i    (wn_mag_q[T_NUM]),
    .den_i    (s_q[T_NUM][DEN_W-1:0]),
    .den_ok_i (s_q[T_NUM] > 0),
    .quo_o    (w_w)
  );

  ppim_div u_div_ty (
    .clk_i    (clk_i),
    .neg_i    (1'b0),
    .num_i    (numy_q),
    .den_i    (h_den),
    .den_ok_i (1'b1),
    .quo_o    (ty_w)
  );

  ppim_div u_div_tx (
    .clk_i    (clk_i),
    .neg_i    (1'b0),
    .num_i    (numx_q),
    .den_i    (h_den),
    .den_ok_i (1'b1),
    .quo_o    (tx_w)
  );

  // Form rho*w and the numerators for the divisions by rho
  always_ff @(posedge clk_i) begin
    w_q[T_RN]  <= w_w;
    ty_q[T_RN] <= ty_w;
    tx_q[T_RN] <= tx_w;
    for (int i = T_RN + 1; i <= T_Q; i++) begin
      w_q[i]  <= w_q[i-1];
      ty_q[i] <= ty_q[i-1];
      tx_q[i] <= tx_q[i-1];
    end
    rw_p_q    <= PROD_W'($signed({1'b0, rho_q[T_W]})) * PROD_W'(w_w);
    rw_q[T_RW] <= sat_w(WIDE_W'(rw_p_q >>> FRAC_W));
    for (int i = T_RW + 1; i <= T_Q; i++) rw_q[i] <= rw_q[i-1];

    rden_q <= DEN_W'(rho_q[T_W]);
    rok_q  <= (rho_q[T_W] != '0);
    rn_neg_q[R_TY]  <= ty_w[DATA_W-1];
    rn_mag_q[R_TY]  <= mag_of(PROD_W'(ty_w)) << FRAC_W;
    rn_neg_q[R_TX]  <= tx_w[DATA_W-1];
    rn_mag_q[R_TX]  <= mag_of(PROD_W'(tx_w)) << FRAC_W;
    rn_neg_q[R_XYH] <= xyh_q[T_W][DATA_W-1];
    rn_mag_q[R_XYH] <= mag_of(PROD_W'(xyh_q[T_W])) << FRAC_W;
    rn_neg_q[R_X]   <= x_q[T_W][DATA_W-1];
    rn_mag_q[R_X]   <= mag_of(PROD_W'(x_q[T_W])) << FRAC_W;
    rn_neg_q[R_Y]   <= y_q[T_W][DATA_W-1];
    rn_mag_q[R_Y]   <= mag_of(PROD_W'(y_q[T_W])) << FRAC_W;
  end

  for (genvar g = 0; g < R_NUM; g++) begin : g_rdiv
    ppim_div u_div_rho (
      .clk_i    (clk_i),
      .neg_i    (rn_neg_q[g]),
      .num_i    (rn_mag_q[g]),
      .den_i    (rden_q),
      .den_ok_i (rok_q),
      .quo_o    (rq_w[g])
    );
  end

  // Combine the terms, saturate, and zero the entries of a degenerate point
  always_ff @(posedge clk_i) begin
    if (deg_q[T_Q]) begin
      u_vx_q      <= '0;
      cross_vel_q <= '0;
      u_vz_q      <= '0;
      u_wx_q      <= '0;
      u_wy_q      <= '0;
      u_wz_q      <= '0;
      v_vy_q      <= '0;
      v_vz_q      <= '0;
      v_wx_q      <= '0;
      v_wy_q      <= '0;
      v_wz_q      <= '0;
    end else begin
      u_vx_q      <= sat_w(-(wide(rq_w[R_TY]) + wide(w_q[T_Q])));
      cross_vel_q <= rq_w[R_XYH];
      u_vz_q      <= rq_w[R_X];
      u_wx_q      <= xyh_q[T_Q];
      u_wy_q      <= sat_w(-(wide(tx_q[T_Q]) + wide(rw_q[T_Q])));
      u_wz_q      <= y_q[T_Q];
      v_vy_q      <= sat_w(-(wide(rq_w[R_TX]) + wide(w_q[T_Q])));
      v_vz_q      <= rq_w[R_Y];
      v_wx_q      <= sat_w(wide(ty_q[T_Q]) + wide(rw_q[T_Q]));
      v_wy_q      <= sat_w(-wide(xyh_q[T_Q]));
      v_wz_q      <= sat_w(-wide(x_q[T_Q]));
    end
    degenerate_q <= deg_q[T_Q];
  end

  assign out_strobe_o = vld_q[T_OUT];
  assign u_vx_o       = u_vx_q;
  assign cross_vel_o  = cross_vel_q;
  assign u_vz_o       = u_vz_q;
  assign u_wx_o       = u_wx_q;
  assign u_wy_o       = u_wy_q;
  assign u_wz_o       = u_wz_q;
  assign v_vy_o       = v_vy_q;
  assign v_vz_o       = v_vz_q;
  assign v_wx_o       = v_wx_q;
  assign v_wy_o       = v_wy_q;
  assign v_wz_o       = v_wz_q;
  assign degenerate_o = degenerate_q;

endmodule
